@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk; the first two are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define SFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfs assertion failed");

// next-cycle implication, off while reset is low
`define SFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfs assertion failed");

// next-cycle implication, also checked across reset
`define SFS_ASSERT_NXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sfs assertion failed");

`endif

@@ sv/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg
// Constants, codes and shared types of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int EDGE_LIMIT  = 5;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        FUNC_RESTART = 2'd0,
        FUNC_SAMPLE  = 2'd1,
        FUNC_TABLE   = 2'd2
    } t_sfs_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_STEP = 3'd0,
        CFG_MOVE_MODE  = 3'd1,
        CFG_REPEAT_TGT = 3'd2,
        CFG_SHIFT_PER  = 3'd3,
        CFG_START_X    = 3'd4,
        CFG_START_Y    = 3'd5,
        CFG_STEP_X     = 3'd6,
        CFG_STEP_Y     = 3'd7
    } t_sfs_cfg_reg;

    typedef struct packed {
        logic [15:0]       frame_step_ms;
        logic              move_mode;
        logic [7:0]        repeat_target;
        logic [7:0]        shift_period;
        logic signed [7:0] start_x;
        logic signed [7:0] start_y;
        logic signed [7:0] step_x;
        logic signed [7:0] step_y;
    } t_sfs_cfg;

    typedef struct packed {
        t_sfs_func   func;
        logic [15:0] time_ms;
        logic [3:0]  table_index;
        logic [7:0]  table_value;
    } t_sfs_item;

    typedef struct packed {
        logic [7:0]        frame_code;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic              done_res;
    } t_sfs_res;

    typedef struct packed {
        logic finished;
    } t_sfs_stat;

endpackage

@@ sv/sfs_core.sv @@
// ----------------------------------------------------------------------------
// sfs_core
// Sequencer state, frame table and the one-pass update for a single word.
// ----------------------------------------------------------------------------
module sfs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  sfs_pkg::t_sfs_item i_item,
    input  sfs_pkg::t_sfs_cfg  i_cfg,
    output sfs_pkg::t_sfs_res  o_res,
    output sfs_pkg::t_sfs_stat o_stat
);
    import sfs_pkg::*;

    localparam logic signed [7:0] EDGE_HI = 8'(EDGE_LIMIT);
    localparam logic signed [7:0] EDGE_LO = -EDGE_HI;

    logic [7:0]        r_store [TABLE_DEPTH];
    logic              r_fin, n_fin;
    logic [TIDX_W-1:0] r_ptr, n_ptr;
    logic [7:0]        r_shc, n_shc;
    logic [7:0]        r_rep, n_rep;
    logic [7:0]        r_shown, n_shown;
    logic [15:0]       r_last, n_last;
    logic signed [7:0] r_x, n_x;
    logic signed [7:0] r_y, n_y;

    logic [15:0]       w_elapsed;
    logic [TIDX_W:0]   w_p1;
    logic              w_done;

    always_comb begin
        n_fin     = r_fin;
        n_ptr     = r_ptr;
        n_shc     = r_shc;
        n_rep     = r_rep;
        n_shown   = r_shown;
        n_last    = r_last;
        n_x       = r_x;
        n_y       = r_y;
        w_done    = 1'b0;
        w_elapsed = 16'd0;
        w_p1      = '0;

        if (i_item.func == FUNC_RESTART) begin
            n_fin   = 1'b0;
            n_ptr   = '0;
            n_shc   = 8'd0;
            n_rep   = 8'd0;
            n_shown = r_store[0];
            n_last  = i_item.time_ms;
            n_x     = i_cfg.move_mode ? i_cfg.start_x : 8'sd0;
            n_y     = i_cfg.move_mode ? i_cfg.start_y : 8'sd0;
        end

        w_elapsed = i_item.time_ms - n_last;
        if ((i_item.func == FUNC_RESTART || i_item.func == FUNC_SAMPLE) && !n_fin
                && w_elapsed >= i_cfg.frame_step_ms) begin
            n_last = i_item.time_ms;
            w_p1   = {1'b0, n_ptr} + (TIDX_W+1)'(1);
            // last slot always reads as terminator
            if (w_p1 >= (TIDX_W+1)'(TABLE_DEPTH - 1)) begin
                n_ptr   = TIDX_W'(TABLE_DEPTH - 1);
                n_shown = 8'd0;
            end else begin
                n_ptr   = w_p1[TIDX_W-1:0];
                n_shown = r_store[w_p1[TIDX_W-1:0]];
            end
            if (n_shown == 8'd0) begin
                n_rep = n_rep + 8'd1;
                if (!i_cfg.move_mode && n_rep == i_cfg.repeat_target) begin
                    w_done = 1'b1;
                end else begin
                    n_ptr   = '0;
                    n_shown = r_store[0];
                end
            end
            if (i_cfg.move_mode) begin
                n_shc = n_shc + 8'd1;
                if (n_shc == i_cfg.shift_period) begin
                    n_shc = 8'd0;
                    n_x   = n_x + i_cfg.step_x;
                    n_y   = n_y + i_cfg.step_y;
                end
                if (n_x <= EDGE_LO || n_x >= EDGE_HI || n_y <= EDGE_LO || n_y >= EDGE_HI) begin
                    w_done = 1'b1;
                end
            end
            if (w_done) begin
                n_fin = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin   <= 1'b1;
            r_ptr   <= '0;
            r_shc   <= 8'd0;
            r_rep   <= 8'd0;
            r_shown <= 8'd0;
            r_last  <= 16'd0;
            r_x     <= 8'sd0;
            r_y     <= 8'sd0;
        end else if (i_go) begin
            r_fin   <= n_fin;
            r_ptr   <= n_ptr;
            r_shc   <= n_shc;
            r_rep   <= n_rep;
            r_shown <= n_shown;
            r_last  <= n_last;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

    // frame table, no reset
    always_ff @(posedge i_clk) begin
        if (i_go && i_item.func == FUNC_TABLE && int'(i_item.table_index) < TABLE_DEPTH) begin
            r_store[TIDX_W'(i_item.table_index)] <= i_item.table_value;
        end
    end

    assign o_res.frame_code = n_shown;
    assign o_res.pos_x      = n_x;
    assign o_res.pos_y      = n_y;
    assign o_res.done_res   = w_done;
    assign o_stat.finished  = r_fin;

endmodule

@@ sv/sprite_frame_sequencer.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Steps a sprite through a loaded table of frame codes, reports frame,
// position and a done pulse.
// ----------------------------------------------------------------------------
// Takes one word per clock. A word is held in the input register; its result
// word is loaded into the result register as the word leaves the input
// register, and from then on is valid on the master side until it is taken.
// The only thing that slows the input is a stalled master side holding a
// result that has not been taken while the next word also produces one.
// Restart (func 0) and time sample (func 1) words each return one result
// word; table writes (func 2) and code 3 return nothing. The done pulse of a
// result travels on tlast and marks the last word of a sequence. After reset
// the sequencer is idle (finished) and time samples report the held frame
// with done low until a restart arrives. A zero code or the last table slot
// ends a pass. Static mode finishes after repeat_target passes and shows
// frame 0; shift mode moves the sprite every shift_period advances and
// finishes once either coordinate reaches the edge limit. Configuration is
// taken at once on i_cfg_we and is read live; write it only while no word is
// in flight. Table slots never written read as unknown.
module sprite_frame_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input words
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [31:0]                      i_s_axis_tdata,  // time_ms, table_index, table_value
    input  logic [1:0]                       i_s_axis_tuser,  // func
    // result words
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [23:0]                      o_m_axis_tdata,  // frame_code, pos_x, pos_y
    output logic                             o_m_axis_tlast   // done_res
);
    import sfs_pkg::*;

    t_sfs_cfg  r_cfg;
    logic      r_in_valid;
    t_sfs_item r_in_item;
    logic      r_out_valid;
    t_sfs_res  r_out_res;

    t_sfs_res  w_res;
    t_sfs_stat w_stat;
    logic      w_has_res;
    logic      w_go;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_step_ms <= 16'd250;
            r_cfg.move_mode     <= 1'b0;
            r_cfg.repeat_target <= 8'd1;
            r_cfg.shift_period  <= 8'd1;
            r_cfg.start_x       <= 8'sd0;
            r_cfg.start_y       <= 8'sd0;
            r_cfg.step_x        <= 8'sd0;
            r_cfg.step_y        <= 8'sd0;
        end else if (i_cfg_we) begin
            case (t_sfs_cfg_reg'(i_cfg_idx))
                CFG_FRAME_STEP: r_cfg.frame_step_ms <= i_cfg_data;
                CFG_MOVE_MODE:  r_cfg.move_mode     <= i_cfg_data[0];
                CFG_REPEAT_TGT: r_cfg.repeat_target <= i_cfg_data[7:0];
                CFG_SHIFT_PER:  r_cfg.shift_period  <= i_cfg_data[7:0];
                CFG_START_X:    r_cfg.start_x       <= $signed(i_cfg_data[7:0]);
                CFG_START_Y:    r_cfg.start_y       <= $signed(i_cfg_data[7:0]);
                CFG_STEP_X:     r_cfg.step_x        <= $signed(i_cfg_data[7:0]);
                CFG_STEP_Y:     r_cfg.step_y        <= $signed(i_cfg_data[7:0]);
                default: ;
            endcase
        end
    end

    // a word without a result never waits on the master side
    assign w_has_res = r_in_item.func == FUNC_RESTART || r_in_item.func == FUNC_SAMPLE;
    assign w_go      = r_in_valid && (!w_has_res || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item.func        <= t_sfs_func'(i_s_axis_tuser);
            r_in_item.time_ms     <= i_s_axis_tdata[15:0];
            r_in_item.table_index <= i_s_axis_tdata[19:16];
            r_in_item.table_value <= i_s_axis_tdata[27:20];
        end
    end

    sfs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res),
        .o_stat  (w_stat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has_res) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_res.pos_y, r_out_res.pos_x, r_out_res.frame_code};
    assign o_m_axis_tlast  = r_out_res.done_res;

`include "assert_macros.svh"

    // reset empties the result register
    `SFS_ASSERT_NXT_RST(a_rst_out_empty, !i_rst_n, !o_m_axis_tvalid)
    // an idle sequencer never reports done on a time sample
    `SFS_ASSERT_IMP(a_idle_no_done, w_go && r_in_item.func == FUNC_SAMPLE && w_stat.finished, !w_res.done_res)
    // a done result leaves the sequencer finished
    `SFS_ASSERT_NXT(a_done_sets_fin, w_go && w_has_res && w_res.done_res, w_stat.finished)

endmodule

@@ bench/sprite_frame_sequencer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_tb
// Self-checking bench for the sprite frame sequencer. A scoreboard class keeps
// its own copy of the table, the counters and the settings, predicts one
// result word per restart or time sample, and checks the master side in order.
// A directed opening is followed by random phases of settings, table loads and
// sample runs, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_tb;
    import sfs_pkg::*;

    // func code 3 has no enum member: the block must drop it silently
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: state of the sequencer, advanced once per accepted word
    // ------------------------------------------------------------------------
    class sprite_track;
        logic [7:0]        codes [TABLE_DEPTH];
        int unsigned       ptr;
        logic [7:0]        shift_cnt;
        logic [7:0]        pass_cnt;
        logic [7:0]        shown;
        logic [15:0]       last_adv;
        logic signed [7:0] x;
        logic signed [7:0] y;
        bit                idle;
        t_sfs_cfg          cfg;
        t_sfs_res          frames_due [$];
        int                fails;

        function new();
            foreach (codes[i]) codes[i] = 8'h00;
            ptr                = 0;
            shift_cnt          = 8'h00;
            pass_cnt           = 8'h00;
            shown              = 8'h00;
            last_adv           = 16'h0000;
            x                  = 8'sd0;
            y                  = 8'sd0;
            idle               = 1'b1;
            cfg.frame_step_ms  = 16'd250;
            cfg.move_mode      = 1'b0;
            cfg.repeat_target  = 8'd1;
            cfg.shift_period   = 8'd1;
            cfg.start_x        = 8'sd0;
            cfg.start_y        = 8'sd0;
            cfg.step_x         = 8'sd0;
            cfg.step_y         = 8'sd0;
            fails              = 0;
        endfunction

        function void set_reg(t_sfs_cfg_reg idx, logic [15:0] val);
            case (idx)
                CFG_FRAME_STEP: cfg.frame_step_ms = val;
                CFG_MOVE_MODE:  cfg.move_mode     = val[0];
                CFG_REPEAT_TGT: cfg.repeat_target = val[7:0];
                CFG_SHIFT_PER:  cfg.shift_period  = val[7:0];
                CFG_START_X:    cfg.start_x       = val[7:0];
                CFG_START_Y:    cfg.start_y       = val[7:0];
                CFG_STEP_X:     cfg.step_x        = val[7:0];
                CFG_STEP_Y:     cfg.step_y        = val[7:0];
                default: ;
            endcase
        endfunction

        function bit off_edge(logic signed [7:0] v);
            return (v <= -EDGE_LIMIT) || (v >= EDGE_LIMIT);
        endfunction

        // one frame advance if enough time has passed; returns the done pulse
        function bit step_frame(logic [15:0] now);
            logic [15:0] gap;
            bit          done;
            done = 1'b0;
            if (idle) return 1'b0;
            gap = now - last_adv;
            if (gap < cfg.frame_step_ms) return 1'b0;
            last_adv = now;
            ptr++;
            // last slot always ends the pass
            if (ptr >= TABLE_DEPTH - 1) begin
                ptr   = TABLE_DEPTH - 1;
                shown = 8'h00;
            end else begin
                shown = codes[ptr];
            end
            if (shown == 8'h00) begin
                pass_cnt++;
                if (!cfg.move_mode && pass_cnt == cfg.repeat_target) begin
                    done = 1'b1;
                end else begin
                    ptr   = 0;
                    shown = codes[0];
                end
            end
            if (cfg.move_mode) begin
                shift_cnt++;
                if (shift_cnt == cfg.shift_period) begin
                    shift_cnt = 8'h00;
                    x += cfg.step_x;
                    y += cfg.step_y;
                end
                if (off_edge(x) || off_edge(y)) done = 1'b1;
            end
            if (done) idle = 1'b1;
            return done;
        endfunction

        // tdata: time_ms[15:0], table_index[19:16], table_value[27:20]
        function void note_word(logic [1:0] fn, logic [31:0] data);
            logic [15:0] now;
            t_sfs_res    r;
            bit          done;
            now = data[15:0];
            if (fn == FUNC_TABLE) begin
                codes[data[19:16]] = data[27:20];
                return;
            end
            if (fn != FUNC_RESTART && fn != FUNC_SAMPLE) return;
            if (fn == FUNC_RESTART) begin
                idle      = 1'b0;
                ptr       = 0;
                shift_cnt = 8'h00;
                pass_cnt  = 8'h00;
                shown     = codes[0];
                last_adv  = now;
                x         = cfg.move_mode ? cfg.start_x : 8'sd0;
                y         = cfg.move_mode ? cfg.start_y : 8'sd0;
            end
            // a restart also counts as a sample
            done         = step_frame(now);
            r.frame_code = shown;
            r.pos_x      = x;
            r.pos_y      = y;
            r.done_res   = done;
            frames_due.push_back(r);
        endfunction

        // tdata: frame_code[7:0], pos_x[15:8], pos_y[23:16]; tlast: done_res
        function void check_word(logic [23:0] data, logic last);
            t_sfs_res want;
            if (frames_due.size() == 0) begin
                $error("result word with nothing pending: %h", data);
                fails++;
                return;
            end
            want = frames_due.pop_front();
            if (data[7:0] !== want.frame_code) begin
                $error("frame_code: expected %0d, actual %0d", want.frame_code, data[7:0]);
                fails++;
            end
            if (data[15:8] !== want.pos_x) begin
                $error("pos_x: expected %0d, actual %0d", want.pos_x, $signed(data[15:8]));
                fails++;
            end
            if (data[23:16] !== want.pos_y) begin
                $error("pos_y: expected %0d, actual %0d", want.pos_y, $signed(data[23:16]));
                fails++;
            end
            if (last !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, last);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic [31:0]           s_data   = '0;   // time_ms, table_index, table_value
    logic [1:0]            s_user   = '0;   // func
    logic                  m_valid;
    logic                  m_ready  = 1'b1;
    logic [23:0]           m_data;          // frame_code, pos_x, pos_y
    logic                  m_last;          // done_res

    sprite_track track = new();

    bit          idle_on    = 1'b1;   // random idle bursts enabled
    int          stall_left = 0;
    int          words_sent = 0;      // excludes ignored func 3 words
    logic [15:0] now_ms     = 16'h0000;

    always #1 clk = ~clk;

    sprite_frame_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    // ------------------------------------------------------------------------
    // Master side: check every accepted result word, stall in random bursts.
    // Values read right after the edge are the ones the edge sampled.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) track.check_word(m_data, m_last);
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pack_word(logic [15:0] t, logic [3:0] idx,
                                              logic [7:0] val);
        return {4'h0, val, idx, t};
    endfunction

    // present one word, optionally after an idle burst, and hold until taken
    task automatic send_word(input logic [1:0] fn, input logic [31:0] data);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= fn;
        s_data  <= data;
        do @(posedge clk); while (!s_ready);
        track.note_word(fn, data);
        if (fn != FUNC_IGNORED) words_sent++;
    endtask

    // write enable stays high across a batch; the caller drops it
    task automatic write_reg(input t_sfs_cfg_reg idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        track.set_reg(idx, val);
    endtask

    task automatic load_settings(input t_sfs_cfg c);
        write_reg(CFG_FRAME_STEP, c.frame_step_ms);
        write_reg(CFG_MOVE_MODE,  {15'h0, c.move_mode});
        write_reg(CFG_REPEAT_TGT, {8'h0, c.repeat_target});
        write_reg(CFG_SHIFT_PER,  {8'h0, c.shift_period});
        write_reg(CFG_START_X,    {8'h0, c.start_x});
        write_reg(CFG_START_Y,    {8'h0, c.start_y});
        write_reg(CFG_STEP_X,     {8'h0, c.step_x});
        write_reg(CFG_STEP_Y,     {8'h0, c.step_y});
        cfg_we <= 1'b0;
    endtask

    // stop sending, let every pending result out, then cover the pipeline
    // for words that return nothing (one register deep)
    task automatic drain();
        s_valid <= 1'b0;
        while (track.frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // One random phase: settings, table load, then a run of mostly samples
    // ------------------------------------------------------------------------
    task automatic random_phase();
        t_sfs_cfg c;
        bit       slow;
        int       len;
        int       n;
        int       r;
        int       d;
        case ($urandom_range(0, 9))
            0:       c.frame_step_ms = 16'd0;
            1:       c.frame_step_ms = 16'hFFFF;
            2:       c.frame_step_ms = 16'($urandom());
            default: c.frame_step_ms = 16'($urandom_range(1, 20));
        endcase
        c.move_mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       c.repeat_target = 8'd0;
            1:       c.repeat_target = 8'd255;
            default: c.repeat_target = 8'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 7))
            0:       c.shift_period = 8'd0;
            1:       c.shift_period = 8'd255;
            default: c.shift_period = 8'($urandom_range(1, 4));
        endcase
        // start near the middle most of the time so the sprite gets to move
        c.start_x = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 8) - 4);
        c.start_y = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 8) - 4);
        case ($urandom_range(0, 7))
            0:       c.step_x = 8'($urandom());
            1:       c.step_x = 8'sd0;
            default: c.step_x = 8'($urandom_range(0, 2) - 1);
        endcase
        case ($urandom_range(0, 7))
            0:       c.step_y = 8'($urandom());
            1:       c.step_y = 8'sd0;
            default: c.step_y = 8'($urandom_range(0, 2) - 1);
        endcase
        // 256 passes or 256 advances per move: one-frame table, no waiting
        slow = c.move_mode ? (c.shift_period == 8'd0) : (c.repeat_target == 8'd0);
        if (slow) c.frame_step_ms = 16'd0;
        load_settings(c);

        // sequence of len codes; below 15 a zero code ends it, else the last slot
        len = slow ? 1 : $urandom_range(1, TABLE_DEPTH - 1);
        for (int i = 0; i < len; i++)
            send_word(FUNC_TABLE, pack_word(16'($urandom()), i[3:0], 8'($urandom_range(1, 255))));
        if (len < TABLE_DEPTH - 1)
            send_word(FUNC_TABLE, pack_word(16'($urandom()), len[3:0], 8'h00));
        if ($urandom_range(0, 3) == 0)
            send_word(FUNC_TABLE, pack_word(16'($urandom()), 4'hF, 8'($urandom())));

        n = slow ? 400 : $urandom_range(60, 160);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if ((track.idle && r < 60) || r < (slow ? 0 : 3)) begin
                if ($urandom_range(0, 3) == 0) now_ms = 16'($urandom());
                send_word(FUNC_RESTART, pack_word(now_ms, 4'($urandom()), 8'($urandom())));
            end else if (r < 90) begin
                // time steps straddle the frame step so advances are hit and missed
                if ($urandom_range(0, 9) == 0)
                    d = $urandom_range(0, 65535);
                else if (c.frame_step_ms <= 16'd20)
                    d = $urandom_range(0, 2 * c.frame_step_ms + 2);
                else
                    d = c.frame_step_ms - 1 + $urandom_range(0, 2);
                now_ms = now_ms + 16'(d);
                send_word(FUNC_SAMPLE, pack_word(now_ms, 4'($urandom()), 8'($urandom())));
            end else if (r < 96) begin
                send_word(FUNC_TABLE, pack_word(16'($urandom()), 4'($urandom()),
                                                8'($urandom())));
            end else begin
                send_word(FUNC_IGNORED, pack_word(16'($urandom()), 4'($urandom()),
                                                  8'($urandom())));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_sfs_cfg c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings (250 ms step, static, one pass).
        // Sample while idle after reset: held frame 0, done low.
        send_word(FUNC_SAMPLE, pack_word(16'd100, 4'h0, 8'h00));
        send_word(FUNC_IGNORED, pack_word(16'hFFFF, 4'hF, 8'hFF));
        // every slot written once so no later read hits an unwritten slot
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (i)
                0:       send_word(FUNC_TABLE, pack_word(16'h0000, 4'd0, 8'hFF));
                1:       send_word(FUNC_TABLE, pack_word(16'h0000, 4'd1, 8'h01));
                2:       send_word(FUNC_TABLE, pack_word(16'h0000, 4'd2, 8'h80));
                3:       send_word(FUNC_TABLE, pack_word(16'h0000, 4'd3, 8'h00));
                15:      send_word(FUNC_TABLE, pack_word(16'hFFFF, 4'd15, 8'hAA));
                default: send_word(FUNC_TABLE, pack_word(16'h0000, i[3:0],
                                                         8'($urandom_range(1, 255))));
            endcase
        end
        // restart just below the time wrap; one ms short, then exact steps
        send_word(FUNC_RESTART, pack_word(16'hFFF0, 4'h0, 8'h00));
        send_word(FUNC_SAMPLE,  pack_word(16'h00E9, 4'h0, 8'h00));
        send_word(FUNC_SAMPLE,  pack_word(16'h00EA, 4'h0, 8'h00));
        send_word(FUNC_SAMPLE,  pack_word(16'h01E4, 4'h0, 8'h00));
        send_word(FUNC_SAMPLE,  pack_word(16'h02DE, 4'h0, 8'h00));  // zero code: done
        send_word(FUNC_SAMPLE,  pack_word(16'h03D8, 4'h0, 8'h00));  // held after done
        drain();

        // Directed, shift mode with zero frame step: the restart itself advances,
        // the sprite reaches the edge and finishes on that same word.
        c.frame_step_ms = 16'd0;
        c.move_mode     = 1'b1;
        c.repeat_target = 8'd1;
        c.shift_period  = 8'd1;
        c.start_x       = 8'sd4;
        c.start_y       = -8'sd4;
        c.step_x        = 8'sd1;
        c.step_y        = 8'sd0;
        load_settings(c);
        send_word(FUNC_RESTART, pack_word(16'h0000, 4'h0, 8'h00));
        send_word(FUNC_SAMPLE,  pack_word(16'h0001, 4'h0, 8'h00));

        // Random phases, each starting from an empty pipeline
        while (words_sent < 1700) begin
            if (words_sent > 1400) idle_on = 1'b0;
            drain();
            random_phase();
        end

        drain();
        repeat (8) @(posedge clk);
        if (track.fails == 0 && track.frames_due.size() == 0)
            $display("sprite_frame_sequencer regression: pass");
        else
            $display("sprite_frame_sequencer regression: fail");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("sprite_frame_sequencer regression: fail");
        $finish;
    end

endmodule

@@ sprite_frame_sequencer.f @@
+incdir+sv
sv/sfs_pkg.sv
sv/sfs_core.sv
sv/sprite_frame_sequencer.sv
bench/sprite_frame_sequencer_tb.sv
